>>> rtl/core/assert_macros.svh
// Assertion macros shared by the interpolator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/core/tci_pkg.sv
// Types and constants of the table cubic interpolator
`timescale 1ns / 1ps
package tci_pkg;
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int FRAC_BITS   = 16;
    localparam int FRAC_W      = FRAC_BITS + 1;
    localparam int LEN_W       = 9;
    localparam int DATA_W      = 32;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int ACC_W       = 40;
    localparam int PROD_W      = ACC_W + FRAC_W + 1;
    localparam int CNT_W       = $clog2(FRAC_BITS + 1);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [FRAC_W-1:0]        t_frac;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [LEN_W-1:0]         t_len;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;
endpackage

>>> rtl/core/tci_if.sv
// Channel interfaces: input items, result items, length register writes
`timescale 1ns / 1ps
interface tci_in_if;
    import tci_pkg::*;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] entry_index;
    t_data      entry_abscissa;
    t_data      entry_ordinate;
    t_data      query_point;
    modport source (output valid, kind, entry_index, entry_abscissa, entry_ordinate,
                    query_point, input ready);
    modport sink   (input valid, kind, entry_index, entry_abscissa, entry_ordinate,
                    query_point, output ready);
endinterface

interface tci_out_if;
    import tci_pkg::*;
    logic  valid;
    logic  ready;
    t_data interp_value;
    logic  out_of_span;
    logic  used_cubic;
    modport source (output valid, interp_value, out_of_span, used_cubic, input ready);
    modport sink   (input valid, interp_value, out_of_span, used_cubic, output ready);
endinterface

interface tci_cfg_if;
    import tci_pkg::*;
    logic valid;
    logic ready;
    t_len data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/tci_div.sv
// Radix-2 restoring divider for the segment fraction, clamped to [0, 1]
`timescale 1ns / 1ps
module tci_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tci_pkg::t_diff i_num,
    input  tci_pkg::t_diff i_den,
    output logic          o_busy,
    output tci_pkg::t_frac o_frac
);
    import tci_pkg::*;

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIFF_W:0]      r_rem;
    logic [DIFF_W-1:0]    r_den;
    logic [FRAC_BITS-1:0] r_quo;
    t_frac                r_frac;

    logic [DIFF_W-1:0]    w_mn, w_md;
    logic [DIFF_W:0]      w_sh;
    logic                 w_bit;
    logic [FRAC_BITS-1:0] w_quo_nx;

    assign w_mn     = i_num[DIFF_W-1] ? (~i_num + 1'b1) : i_num;
    assign w_md     = i_den[DIFF_W-1] ? (~i_den + 1'b1) : i_den;
    assign w_sh     = {r_rem[DIFF_W-1:0], 1'b0};
    assign w_bit    = w_sh >= {1'b0, r_den};
    assign w_quo_nx = {r_quo[FRAC_BITS-2:0], w_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rem <= {1'b0, w_mn};
            r_den <= w_md;
            r_quo <= '0;
            r_cnt <= CNT_W'(FRAC_BITS);
            r_busy <= 1'b0;
            // zero width, zero offset, or wrong side of x[i] all give zero
            if (w_md == '0 || w_mn == '0 || (i_num[DIFF_W-1] != i_den[DIFF_W-1])) begin
                r_frac <= '0;
            end else if (w_mn >= w_md) begin
                r_frac <= FRAC_W'(1) << FRAC_BITS;
            end else begin
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            r_rem <= w_bit ? (w_sh - {1'b0, r_den}) : w_sh;
            r_quo <= w_quo_nx;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_frac <= {1'b0, w_quo_nx};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_frac = r_frac;
endmodule

>>> rtl/core/tci_mul.sv
// Two-stage multiply by the fraction with round to nearest, ties away from zero
`timescale 1ns / 1ps
module tci_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tci_pkg::t_acc  i_a,
    input  tci_pkg::t_frac i_f,
    output logic           o_done,
    output tci_pkg::t_acc  o_res
);
    import tci_pkg::*;

    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    logic                     r_v1, r_v2;
    logic signed [PROD_W-1:0] r_p;
    t_acc                     r_res;

    logic signed [FRAC_W:0] w_fs;
    logic [PROD_W-1:0]      w_mag, w_m;

    assign w_fs  = {1'b0, i_f};
    assign w_mag = r_p[PROD_W-1] ? (~r_p + 1'b1) : r_p;
    assign w_m   = (w_mag + HALF) >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
        r_p   <= i_a * w_fs;
        r_res <= r_p[PROD_W-1] ? ACC_W'(~w_m + 1'b1) : ACC_W'(w_m);
    end

    assign o_done = r_v2;
    assign o_res  = r_res;
endmodule

>>> rtl/core/table_cubic_interpolator.sv
// Top level: table store, lookup sequencer and shared arithmetic units
//
// Channels: i_in takes items (kind 0 loads x/y at entry_index, kind 1 is a
// query), o_out returns one result per query, i_cfg writes table_length.
// Items and results transfer when valid and ready are both high; the
// configuration channel is always ready.
// A load writes the table at its transfer and gives no result. A query
// reads x[0] and x[n-1] first; a point beyond the last entry returns that
// entry's y with out_of_span set, a point before the first entry the first y.
// Otherwise a bisection (one table read per step, up to 8 steps), two
// segment reads, a bit-serial division overlapping the two neighbour reads
// and the coefficient step (skipped when the fraction is 0 or 1) and one or
// three multiplier passes give the result. The next item can transfer in
// the cycle after the result; the single read port and the divider set how
// long a query occupies the block.
// The block accepts no item while a query is at work or its result waits;
// a stalled receiver simply holds the block in that state.
// Synchronous reset returns to idle and sets table_length to 2; table
// contents are undefined until loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module table_cubic_interpolator (
    input  logic i_clk,
    input  logic i_rst_n,
    tci_in_if.sink    i_in,
    tci_out_if.source o_out,
    tci_cfg_if.sink   i_cfg
);
    import tci_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RX0, S_RXL, S_RY0, S_BIS, S_RXI, S_RXI1, S_RYM, S_RY2,
        S_COEF, S_WDIV, S_MSTART, S_MWAIT, S_OUT
    } t_state;

    t_state r_state;
    t_len   r_len;
    t_data  r_q, r_x0, r_xi, r_y0, r_y1, r_ym, r_y2;
    t_idx   r_n1, r_lo, r_hi, r_mid;
    logic   r_asc, r_cubic;
    t_acc   r_a0, r_a1, r_a2, r_acc;
    t_frac  r_f;
    logic [1:0] r_step;
    t_data  r_oval;
    logic   r_oos, r_ocub;

    logic [DATA_W-1:0] r_xmem [TABLE_DEPTH];
    logic [DATA_W-1:0] r_ymem [TABLE_DEPTH];
    t_data  r_xrd, r_yrd;

    t_idx   w_addr, w_len_n1, w_lo_nx, w_hi_nx, w_mid_nx;
    logic   w_asc, w_above, w_below, w_ge, w_more;
    t_diff  w_num, w_den;
    logic   w_div_busy, w_mul_done;
    t_frac  w_div_frac;
    t_acc   w_mul_res, w_addend, w_sum;
    t_data  w_sat;
    logic   w_last;

    // effective length, held as n-1
    always_comb begin
        if (r_len < LEN_W'(2))
            w_len_n1 = t_idx'(1);
        else if (r_len > LEN_W'(TABLE_DEPTH))
            w_len_n1 = t_idx'(TABLE_DEPTH - 1);
        else
            w_len_n1 = t_idx'(r_len - 1'b1);
    end

    assign w_asc   = r_x0 < r_xrd;
    assign w_above = w_asc ? (r_q > r_xrd) : (r_q < r_xrd);
    assign w_below = w_asc ? (r_q < r_x0) : (r_q > r_x0);
    assign w_ge    = r_q >= r_xrd;

    always_comb begin
        w_lo_nx = r_lo;
        w_hi_nx = r_hi;
        if (r_state == S_RXL) begin
            w_lo_nx = '0;
            w_hi_nx = r_n1;
        end else if (r_state == S_BIS) begin
            if (w_ge == r_asc) w_lo_nx = r_mid;
            else               w_hi_nx = r_mid;
        end
    end
    assign w_mid_nx = t_idx'(({1'b0, w_lo_nx} + {1'b0, w_hi_nx}) >> 1);
    assign w_more   = (w_hi_nx - w_lo_nx) > t_idx'(1);

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_addr = '0;
            S_RX0:   w_addr = r_n1;
            S_RXL:   w_addr = (w_below || !w_more) ? t_idx'(0) : w_mid_nx;
            S_BIS:   w_addr = w_more ? w_mid_nx : w_lo_nx;
            S_RXI:   w_addr = r_lo + 1'b1;
            S_RXI1:  w_addr = r_lo - 1'b1;
            S_RYM:   w_addr = r_lo + t_idx'(2);
            default: w_addr = r_lo;
        endcase
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready && i_in.kind == KIND_LOAD) begin
            r_xmem[i_in.entry_index] <= i_in.entry_abscissa;
            r_ymem[i_in.entry_index] <= i_in.entry_ordinate;
        end
        r_xrd <= r_xmem[w_addr];
        r_yrd <= r_ymem[w_addr];
    end

    assign w_num = {r_q[DATA_W-1], r_q} - {r_xi[DATA_W-1], r_xi};
    assign w_den = {r_xrd[DATA_W-1], r_xrd} - {r_xi[DATA_W-1], r_xi};

    tci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_RXI1),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_frac  (w_div_frac)
    );

    tci_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MSTART),
        .i_a     (r_acc),
        .i_f     (r_f),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    // Horner steps add a1, a2, then y0; linear adds y0 once
    always_comb begin
        if (!r_cubic || r_step == 2'd2) w_addend = ACC_W'(r_y0);
        else if (r_step == 2'd0)        w_addend = r_a1;
        else                            w_addend = r_a2;
    end
    assign w_last = !r_cubic || r_step == 2'd2;
    assign w_sum  = w_mul_res + w_addend;

    always_comb begin
        if (&w_sum[ACC_W-1:DATA_W-1] || ~|w_sum[ACC_W-1:DATA_W-1])
            w_sat = w_sum[DATA_W-1:0];
        else if (w_sum[ACC_W-1])
            w_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            w_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= LEN_W'(2);
        end else begin
            if (i_cfg.valid) r_len <= i_cfg.data;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.kind == KIND_QUERY) begin
                        r_q     <= i_in.query_point;
                        r_n1    <= w_len_n1;
                        r_state <= S_RX0;
                    end
                end
                S_RX0: begin
                    r_x0    <= r_xrd;
                    r_state <= S_RXL;
                end
                S_RXL: begin
                    r_asc <= w_asc;
                    r_lo  <= w_lo_nx;
                    r_hi  <= w_hi_nx;
                    r_mid <= w_mid_nx;
                    if (w_above) begin
                        r_oval  <= r_yrd;
                        r_oos   <= 1'b1;
                        r_ocub  <= 1'b0;
                        r_state <= S_OUT;
                    end else if (w_below) begin
                        r_state <= S_RY0;
                    end else begin
                        r_state <= w_more ? S_BIS : S_RXI;
                    end
                end
                S_RY0: begin
                    r_oval  <= r_yrd;
                    r_oos   <= 1'b1;
                    r_ocub  <= 1'b0;
                    r_state <= S_OUT;
                end
                S_BIS: begin
                    r_lo  <= w_lo_nx;
                    r_hi  <= w_hi_nx;
                    r_mid <= w_mid_nx;
                    if (!w_more) r_state <= S_RXI;
                end
                S_RXI: begin
                    r_xi    <= r_xrd;
                    r_y0    <= r_yrd;
                    r_state <= S_RXI1;
                end
                S_RXI1: begin
                    r_y1    <= r_yrd;
                    r_cubic <= (r_lo > t_idx'(1)) &&
                               ({1'b0, r_lo} + (IDX_W+1)'(2) <= {1'b0, r_n1});
                    r_state <= S_RYM;
                end
                S_RYM: begin
                    r_ym    <= r_yrd;
                    r_state <= S_RY2;
                end
                S_RY2: begin
                    r_y2    <= r_yrd;
                    r_state <= S_COEF;
                end
                S_COEF: begin
                    r_a0 <= ACC_W'(r_y2) - ACC_W'(r_y1) - ACC_W'(r_ym) + ACC_W'(r_y0);
                    r_state <= S_WDIV;
                end
                S_WDIV: begin
                    r_a1 <= ACC_W'(r_ym) - ACC_W'(r_y0) - r_a0;
                    r_a2 <= ACC_W'(r_y1) - ACC_W'(r_ym);
                    if (!w_div_busy) begin
                        r_f     <= w_div_frac;
                        r_acc   <= r_cubic ? r_a0 : (ACC_W'(r_y1) - ACC_W'(r_y0));
                        r_step  <= 2'd0;
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (w_mul_done) begin
                        if (w_last) begin
                            r_oval  <= w_sat;
                            r_oos   <= 1'b0;
                            r_ocub  <= r_cubic;
                            r_state <= S_OUT;
                        end else begin
                            r_acc   <= w_sum;
                            r_step  <= r_step + 1'b1;
                            r_state <= S_MSTART;
                        end
                    end
                end
                S_OUT: begin
                    if (o_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = (r_state == S_OUT);
    assign o_out.interp_value = r_oval;
    assign o_out.out_of_span  = r_oos;
    assign o_out.used_cubic   = r_ocub;

    `ASSERT_IMPL(a_no_accept_while_pending, i_clk, i_rst_n, o_out.valid, !i_in.ready, "input ready while result pending")
    `ASSERT_NEVER(a_flags_exclusive, i_clk, i_rst_n, o_out.valid && o_out.out_of_span && o_out.used_cubic, "clamped result flagged cubic")
    `ASSERT_IMPL(a_div_window, i_clk, i_rst_n, w_div_busy, (r_state == S_RYM) || (r_state == S_RY2) || (r_state == S_COEF) || (r_state == S_WDIV), "divider busy outside its window")
    `ASSERT_IMPL(a_mul_window, i_clk, i_rst_n, w_mul_done, r_state == S_MWAIT, "multiplier result outside wait state")
endmodule

>>> tb/table_cubic_interpolator_tb.sv
// Self-checking testbench for the table cubic interpolator: random tables, queries, scoreboard
`timescale 1ns / 1ps
module table_cubic_interpolator_tb;
    import tci_pkg::*;

    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  DRAIN_CYCLES = 60;
    localparam int  NUM_PHASES = 12;
    localparam longint ONE_Q = 64'sd1 << FRAC_BITS;

    typedef enum int {SHAPE_ASCEND, SHAPE_DESCEND, SHAPE_FLAT, SHAPE_SCRAMBLED} t_shape;

    typedef struct {
        t_data value;
        logic  beyond;
        logic  cubic;
    } t_answer;

    class interp_scoreboard;
        t_data   x_col[TABLE_DEPTH];
        t_data   y_col[TABLE_DEPTH];
        t_len    length_reg;
        t_answer answers[$];
        int      errors;

        function new();
            length_reg = 2;
            errors = 0;
        endfunction

        function int span_len();
            if (length_reg < 2) return 2;
            if (length_reg > TABLE_DEPTH) return TABLE_DEPTH;
            return int'(length_reg);
        endfunction

        // product with the fraction, rounded half away from zero
        function longint scale_frac(longint a, longint f);
            longint p;
            longint m;
            p = a * f;
            m = ((p < 0 ? -p : p) + (ONE_Q >>> 1)) >>> FRAC_BITS;
            return p < 0 ? -m : m;
        endfunction

        function void note_item(logic kind, logic [7:0] idx, t_data x, t_data y, t_data q);
            int      n, lo, hi, mid, seg;
            longint  qq, x0, xl, num, den, mq, f, v;
            longint  ym, y0, y1, y2, a0, a1, a2;
            bit      asc;
            t_answer ans;
            if (kind == KIND_LOAD) begin
                x_col[idx] = x;
                y_col[idx] = y;
                return;
            end
            n = span_len();
            qq = q;
            x0 = x_col[0];
            xl = x_col[n-1];
            asc = x0 < xl;
            ans.beyond = 1'b1;
            ans.cubic = 1'b0;
            if ((asc && qq > xl) || (!asc && qq < xl)) begin
                ans.value = y_col[n-1];
                answers.insert(answers.size(), ans);
                return;
            end
            if ((asc && qq < x0) || (!asc && qq > x0)) begin
                ans.value = y_col[0];
                answers.insert(answers.size(), ans);
                return;
            end
            lo = 0;
            hi = n - 1;
            while (hi - lo > 1) begin
                mid = (lo + hi) >> 1;
                if ((qq >= longint'(x_col[mid])) == asc) lo = mid;
                else hi = mid;
            end
            seg = lo;
            num = qq - longint'(x_col[seg]);
            den = longint'(x_col[seg+1]) - longint'(x_col[seg]);
            if (den == 0) begin
                f = 0;
            end else begin
                mq = ((num < 0 ? -num : num) << FRAC_BITS) / (den < 0 ? -den : den);
                if (mq != 0 && ((num < 0) != (den < 0))) f = 0;
                else f = mq > ONE_Q ? ONE_Q : mq;
            end
            y0 = y_col[seg];
            y1 = y_col[seg+1];
            if (seg > 1 && seg < n - 2) begin
                ym = y_col[seg-1];
                y2 = y_col[seg+2];
                a0 = y2 - y1 - ym + y0;
                a1 = ym - y0 - a0;
                a2 = y1 - ym;
                v = scale_frac(scale_frac(scale_frac(a0, f) + a1, f) + a2, f) + y0;
                ans.cubic = 1'b1;
            end else begin
                v = y0 + scale_frac(y1 - y0, f);
            end
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            ans.value = t_data'(v);
            ans.beyond = 1'b0;
            answers.insert(answers.size(), ans);
        endfunction

        function void check_result(t_data value, logic beyond, logic cubic);
            t_answer want;
            if (answers.size() == 0) begin
                $error("unexpected result: interp_value %0d", value);
                errors++;
                return;
            end
            want = answers.pop_front();
            if (value !== want.value) begin
                $error("interp_value: expected %0d, actual %0d", want.value, value);
                errors++;
            end
            if (beyond !== want.beyond) begin
                $error("out_of_span: expected %0b, actual %0b", want.beyond, beyond);
                errors++;
            end
            if (cubic !== want.cubic) begin
                $error("used_cubic: expected %0b, actual %0b", want.cubic, cubic);
                errors++;
            end
        endfunction

        function int pending();
            return answers.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    tci_in_if  in_if();
    tci_out_if out_if();
    tci_cfg_if cfg_if();

    table_cubic_interpolator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    interp_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= 400;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.interp_value, out_if.out_of_span, out_if.used_cubic);
    end

    task automatic send_item(logic kind, logic [7:0] idx, t_data x, t_data y, t_data q);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.kind <= kind;
        in_if.entry_index <= idx;
        in_if.entry_abscissa <= x;
        in_if.entry_ordinate <= y;
        in_if.query_point <= q;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_item(kind, idx, x, y, q);
    endtask

    task automatic load_entry(int idx, t_data x, t_data y);
        send_item(KIND_LOAD, 8'(idx), x, y, t_data'($urandom));
    endtask

    task automatic query_at(t_data q);
        send_item(KIND_QUERY, 8'($urandom), t_data'($urandom), t_data'($urandom), q);
    endtask

    // pause until every result is back, then let the block settle
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(t_len value);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.length_reg = value;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic build_table(int n, t_shape shape);
        longint xv, max_step, step;
        int     y_mode, shift;
        t_data  y;
        max_step = 64'd4294967000 / n;
        shift = ($urandom_range(3) == 0) ? 30 : $urandom_range(0, 24);
        xv = (shape == SHAPE_DESCEND) ? 64'sd2147483647 - $urandom_range(0, 500)
                                      : -64'sd2147483648 + $urandom_range(0, 500);
        y_mode = $urandom_range(2);
        for (int k = 0; k < n; k++) begin
            case (y_mode)
                0: y = t_data'($urandom);
                1: y = (k % 2) ? 32'sh7fffffff : 32'sh80000000;
                default: y = t_data'(k * 65536 + $urandom_range(0, 40000) - 20000);
            endcase
            case (shape)
                SHAPE_FLAT:      load_entry(k, t_data'(xv), y);
                SHAPE_SCRAMBLED: load_entry(k, t_data'($urandom), y);
                default:         load_entry(k, t_data'(xv), y);
            endcase
            step = (max_step >>> shift);
            step = ($urandom_range(9) == 0) ? 0 : longint'($urandom_range(1, 32'(step + 1)));
            if (step > max_step) step = max_step;
            if (shape == SHAPE_DESCEND) xv = xv - step;
            else if (shape == SHAPE_ASCEND) xv = xv + step;
        end
    endtask

    task automatic random_query(int n);
        int     k, pick;
        longint lo, hi;
        pick = $urandom_range(99);
        k = $urandom_range(0, n - 2);
        lo = sb.x_col[k];
        hi = sb.x_col[k+1];
        if (pick < 60)
            query_at(t_data'(lo + ((longint'($urandom) * (hi - lo)) >>> 32)));
        else if (pick < 75)
            query_at(sb.x_col[$urandom_range(0, n - 1)]);
        else if (pick < 85)
            query_at(t_data'($urandom));
        else if (pick < 92)
            query_at($urandom_range(1) ? 32'sh7fffffff : 32'sh80000000);
        else if (pick < 96)
            query_at(t_data'(longint'(sb.x_col[n-1]) + ($urandom_range(1) ? 1 : -1)));
        else
            load_entry($urandom_range(0, 255), t_data'($urandom), t_data'($urandom));
    endtask

    initial begin
        t_len   len_val;
        t_shape shape;
        int     n, p;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.kind <= KIND_LOAD;
        in_if.entry_index <= '0;
        in_if.entry_abscissa <= '0;
        in_if.entry_ordinate <= '0;
        in_if.query_point <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme abscissae, alternating full-scale ordinates
        write_length(9'd6);
        load_entry(0, 32'sh80000000, 32'sh7fffffff);
        load_entry(1, -1000, 32'sh80000000);
        load_entry(2, 0, 32'sh7fffffff);
        load_entry(3, 1000, 32'sh80000000);
        load_entry(4, 2000, 32'sh7fffffff);
        load_entry(5, 32'sh7fffffff, 32'sh80000000);
        query_at(32'sh80000000);
        query_at(32'sh7fffffff);
        query_at(0);
        query_at(-500);
        query_at(500);
        query_at(1500);
        query_at(1999);
        query_at(32'sh40000000);
        query_at(-32'sh40000000);
        // zero-width segment in the middle
        load_entry(3, 0, 12345);
        query_at(0);
        query_at(1);
        wait_drained();
        // length 0 acts as two entries; equal ends read as descending
        write_length(9'd0);
        load_entry(0, 777, -5);
        load_entry(1, 777, 9);
        query_at(777);
        query_at(776);
        query_at(778);
        wait_drained();

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p < NUM_PHASES / 3) begin
                send_idle_pct = 20;
                recv_idle_pct = 56;
            end else if (p < 2 * NUM_PHASES / 3) begin
                send_idle_pct = 56;
                recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: len_val = 9'd256;
                1: len_val = 9'd5;
                2: len_val = 9'd511;
                3: len_val = 9'd1;
                4: len_val = 9'd3;
                5: len_val = 9'd4;
                default: len_val = t_len'($urandom_range(2, 60));
            endcase
            write_length(len_val);
            n = sb.span_len();
            case (p % 4)
                0: shape = SHAPE_ASCEND;
                1: shape = SHAPE_DESCEND;
                2: shape = ($urandom_range(1) ? SHAPE_SCRAMBLED : SHAPE_FLAT);
                default: shape = ($urandom_range(1) ? SHAPE_ASCEND : SHAPE_DESCEND);
            endcase
            build_table(n, shape);
            if (p == 7) hold_token = hold_token + 1;
            for (int k = 0; k < 80; k++) random_query(n);
            wait_drained();
        end

        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
